[hdl/nshot_pkg.sv]
package nshot_pkg;

   localparam int MAX_ENTRIES         = 4;
   localparam int NUM_ENTRIES_DEFAULT = 4;

   localparam int KEY_W   = 16;
   localparam int MODS_W  = 8;
   localparam int COUNT_W = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_CODES  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SHOTS      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODIFIER_MASKS = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROLL_ENABLES   = 8'd3;

   localparam logic [63:0] TRIGGER_CODES_RESET  = 64'h0;
   localparam logic [31:0] MAX_SHOTS_RESET      = 32'h0101_0101;
   localparam logic [31:0] MODIFIER_MASKS_RESET = 32'h0;
   localparam logic [3:0]  ROLL_ENABLES_RESET   = 4'h0;

   typedef enum logic [1:0] {
      MODE_IDLE        = 2'd0,
      MODE_DOWN_UNUSED = 2'd1,
      MODE_DOWN_USED   = 2'd2,
      MODE_QUEUED      = 2'd3
   } mode_type;

   typedef struct packed {
      logic [KEY_W-1:0] keycode;
      logic             action;
      logic             is_cancel;
      logic             is_ignored;
   } key_event_type;

   typedef struct packed {
      logic [KEY_W-1:0]   trigger;
      logic [MODS_W-1:0]  mask;
      logic [COUNT_W-1:0] target;
      logic               roll;
   } entry_cfg_type;

   typedef struct packed {
      logic [MODS_W-1:0] press_mask;
      logic [MODS_W-1:0] rel_mask;
   } entry_out_type;

endpackage

[hdl/nshot_csr.sv]
module nshot_csr import nshot_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output entry_cfg_type          entry_cfg [MAX_ENTRIES]
);

   logic [63:0] trigger_codes_ff, trigger_codes_in;
   logic [31:0] max_shots_ff, max_shots_in;
   logic [31:0] modifier_masks_ff, modifier_masks_in;
   logic [3:0]  roll_enables_ff, roll_enables_in;

   assign csr_ready = 1'b1;

   always_comb begin
      trigger_codes_in  = trigger_codes_ff;
      max_shots_in      = max_shots_ff;
      modifier_masks_in = modifier_masks_ff;
      roll_enables_in   = roll_enables_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TRIGGER_CODES:  trigger_codes_in  = csr_wdata;
            CSR_MAX_SHOTS:      max_shots_in      = csr_wdata[31:0];
            CSR_MODIFIER_MASKS: modifier_masks_in = csr_wdata[31:0];
            CSR_ROLL_ENABLES:   roll_enables_in   = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_codes_ff  <= TRIGGER_CODES_RESET;
         max_shots_ff      <= MAX_SHOTS_RESET;
         modifier_masks_ff <= MODIFIER_MASKS_RESET;
         roll_enables_ff   <= ROLL_ENABLES_RESET;
      end else begin
         trigger_codes_ff  <= trigger_codes_in;
         max_shots_ff      <= max_shots_in;
         modifier_masks_ff <= modifier_masks_in;
         roll_enables_ff   <= roll_enables_in;
      end
   end

   // target is twice the shot limit, wrapped to the counter width
   always_comb begin
      for (int e = 0; e < MAX_ENTRIES; e++) begin
         entry_cfg[e].trigger = trigger_codes_ff[KEY_W*e +: KEY_W];
         entry_cfg[e].mask    = modifier_masks_ff[MODS_W*e +: MODS_W];
         entry_cfg[e].target  = {max_shots_ff[COUNT_W*e +: COUNT_W-1], 1'b0};
         entry_cfg[e].roll    = roll_enables_ff[e];
      end
   end

endmodule

[hdl/nshot_entry.sv]
module nshot_entry import nshot_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  key_event_type ev,
   input  entry_cfg_type cfg,
   output entry_out_type result
);

   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               skd_ff, skd_in;
   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] count_rel;
   logic               is_trigger;

   assign is_trigger = (ev.keycode == cfg.trigger);
   assign count_inc  = count_ff + COUNT_W'(1);
   // a release counts only once a key went down after the trigger press, or with roll
   assign count_rel  = skd_ff ? count_inc : count_ff;

   // next state
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      skd_in   = skd_ff;
      if (fire) begin
         if (is_trigger) begin
            if (ev.action) begin
               mode_in  = MODE_DOWN_UNUSED;
               count_in = '0;
               skd_in   = cfg.roll;
            end else if (mode_ff == MODE_DOWN_UNUSED) begin
               mode_in = MODE_QUEUED;
            end else if (mode_ff == MODE_DOWN_USED) begin
               mode_in = MODE_IDLE;
            end
         end else if (ev.action) begin
            if (ev.is_cancel && mode_ff != MODE_IDLE) begin
               mode_in  = MODE_IDLE;
               count_in = '0;
               skd_in   = cfg.roll;
            end else if (mode_ff == MODE_QUEUED && !ev.is_ignored) begin
               if (count_inc == cfg.target) begin
                  mode_in  = MODE_IDLE;
                  count_in = '0;
                  skd_in   = cfg.roll;
               end else begin
                  count_in = count_inc;
                  skd_in   = 1'b1;
               end
            end else if (mode_ff == MODE_DOWN_UNUSED) begin
               skd_in = 1'b1;
            end
         end else if (!ev.is_ignored) begin
            if (mode_ff == MODE_DOWN_UNUSED) begin
               if (skd_ff) mode_in = MODE_DOWN_USED;
            end else if (mode_ff == MODE_QUEUED) begin
               if (count_rel == cfg.target) begin
                  mode_in  = MODE_IDLE;
                  count_in = '0;
                  skd_in   = cfg.roll;
               end else begin
                  count_in = count_rel;
               end
            end
         end
      end
   end

   // outputs: every drop from an active mode back to idle unregisters the mask
   always_comb begin
      result.press_mask = (fire && is_trigger && ev.action && mode_ff == MODE_IDLE)
                          ? cfg.mask : '0;
      result.rel_mask   = (fire && mode_ff != MODE_IDLE && mode_in == MODE_IDLE)
                          ? cfg.mask : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         skd_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         skd_ff   <= skd_in;
      end
   end

endmodule

[hdl/nshot_modifier_fsm_unit.sv]
// channel   | ports                                          | direction
// ----------+------------------------------------------------+----------
// request   | req_valid/req_ready, keycode, action, flags    | in
// response  | rsp_valid/rsp_ready, mods_press, mods_release  | out
// csr write | csr_valid/csr_ready, csr_index, csr_wdata      | in
//
// one request per cycle sustained while responses are taken; the response
// register loads as the request leaves the input register: one input register,
// then all entries update in parallel with the response register load.
// reset returns every entry to up idle and the registers to their defaults.
// a stalled response holds the pipe; the input register still takes a
// request while it is empty.
module nshot_modifier_fsm_unit import nshot_pkg::*; #(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [KEY_W-1:0]       req_keycode,
   input  logic                   req_action,
   input  logic                   req_is_cancel,
   input  logic                   req_is_ignored,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [MODS_W-1:0]      rsp_mods_press,
   output logic [MODS_W-1:0]      rsp_mods_release,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   entry_cfg_type entry_cfg [MAX_ENTRIES];
   entry_out_type entry_res [NUM_ENTRIES];

   key_event_type     event_ff, event_in;
   logic              in_valid_ff, in_valid_in;
   logic              out_valid_ff, out_valid_in;
   logic [MODS_W-1:0] press_ff, press_in;
   logic [MODS_W-1:0] rel_ff, rel_in;
   logic              fire;
   logic              req_take;

   nshot_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .entry_cfg (entry_cfg)
   );

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_take  = req_valid && req_ready;

   for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_entry
      nshot_entry u_entry (
         .clock  (clock),
         .reset  (reset),
         .fire   (fire),
         .ev     (event_ff),
         .cfg    (entry_cfg[e]),
         .result (entry_res[e])
      );
   end

   always_comb begin
      event_in.keycode    = req_keycode;
      event_in.action     = req_action;
      event_in.is_cancel  = req_is_cancel;
      event_in.is_ignored = req_is_ignored;
      in_valid_in  = req_take || (in_valid_ff && !fire);
      out_valid_in = fire || (out_valid_ff && !rsp_ready);
      press_in = '0;
      rel_in   = '0;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
         press_in = press_in | entry_res[e].press_mask;
         rel_in   = rel_in | entry_res[e].rel_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) event_ff <= event_in;
      if (fire) begin
         press_ff <= press_in;
         rel_ff   <= rel_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mods_press   = press_ff;
   assign rsp_mods_release = rel_ff;

endmodule

[hdl/nshot_checker.sv]
module nshot_checker import nshot_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [MODS_W-1:0] rsp_mods_press,
   input logic [MODS_W-1:0] rsp_mods_release,
   input logic              csr_ready
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_mods_press) && $stable(rsp_mods_release))
      else $error("response changed while stalled");

   // the input side only stalls behind a stalled response
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a response backlog");

   // once an accepted request has left the input register a response is pending
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("no response after accepted request");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready && csr_ready)
      else $error("pipe not empty after reset");

endmodule

bind nshot_modifier_fsm_unit nshot_checker u_nshot_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_mods_press   (rsp_mods_press),
   .rsp_mods_release (rsp_mods_release),
   .csr_ready        (csr_ready)
);
